@@ src/rdt_pkg.sv @@
package rdt_pkg;

  // Field widths
  localparam int unsigned NowW      = 63;
  localparam int unsigned DeadlineW = 64;
  localparam int unsigned TimeoutW  = 31;
  localparam int unsigned CfgW      = 32;
  localparam int unsigned StepW     = 42;  // the alignment step in us fits in 42 bits
  localparam int unsigned CntW      = 6;   // one divider step per dividend bit

  localparam logic [DeadlineW-1:0] DeadlineMax = {1'b0, {(DeadlineW-1){1'b1}}};
  localparam logic [TimeoutW-1:0]  TimeoutMax  = {TimeoutW{1'b1}};
  localparam logic [StepW-1:0]     UsPerMs     = StepW'(1000);
  localparam logic [DeadlineW-1:0] MsRoundUp   = DeadlineW'(999);

  // Microseconds to milliseconds: drop 3 bits (1000 = 8 * 125), then multiply by
  // the rounded-up reciprocal of 125, ten multiplier bits per step
  localparam int unsigned UsShift    = 3;
  localparam int unsigned ScaledW    = 38;  // saturation bound over 8 fits in 38 bits
  localparam int unsigned ChunkW     = 10;
  localparam int unsigned MulSteps   = 4;
  localparam int unsigned RecipW     = ChunkW * MulSteps;
  localparam int unsigned RecipShift = 45;
  localparam int unsigned QuoShift   = RecipShift - RecipW;
  localparam logic [DeadlineW-1:0] TmoSatUs = 64'd2147483648000;  // 2^31 ms in us
  localparam logic [RecipW-1:0]    TmoRecip =
      RecipW'(((64'd1 << RecipShift) + 64'd124) / 64'd125);

  typedef enum logic [1:0] {
    REQ_POLL = 2'd0,
    REQ_ARM  = 2'd1,
    REQ_FIRE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    CFG_INTERVAL    = 2'd0,
    CFG_GRANULARITY = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV_MOD,
    ST_SNAP,
    ST_EVAL,
    ST_MUL_TMO,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]     req_type;
    logic [NowW-1:0] now_us;
  } in_t;

  typedef struct packed {
    logic                        due;
    logic [TimeoutW-1:0]         tmo_ms;
    logic signed [DeadlineW-1:0] deadline_us;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture the request
    logic arm;       // form now + interval and start the modulo
    logic fire;      // deadline takes now
    logic div_step;  // one restoring division step
    logic snap;      // align and saturate the armed deadline
    logic eval;      // compare and start the timeout multiply
    logic mul_step;  // one reciprocal multiply step
    logic out_load;  // fill the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    req_e req;
    logic gran_zero;
    logic div_last;
    logic mul_last;
  } sts_t;

  // x * 1000 as shifts and subtracts
  function automatic logic [StepW-1:0] times_1000(input logic [CfgW-1:0] x);
    logic [StepW-1:0] xw;
    xw = StepW'(x);
    return (xw << 10) - (xw << 4) - (xw << 3);
  endfunction

endpackage

@@ src/rdt_ctrl.sv @@
module rdt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  rdt_pkg::sts_t sts_i,
  output rdt_pkg::cmd_t cmd_o
);

  rdt_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rdt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      rdt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = rdt_pkg::ST_DECODE;
        end
      end
      rdt_pkg::ST_DECODE: begin
        if (sts_i.req == rdt_pkg::REQ_ARM) begin
          cmd_o.arm = 1'b1;
          state_d   = sts_i.gran_zero ? rdt_pkg::ST_SNAP : rdt_pkg::ST_DIV_MOD;
        end else begin
          cmd_o.fire = (sts_i.req == rdt_pkg::REQ_FIRE);
          state_d    = rdt_pkg::ST_EVAL;
        end
      end
      rdt_pkg::ST_DIV_MOD: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = rdt_pkg::ST_SNAP;
        end
      end
      rdt_pkg::ST_SNAP: begin
        cmd_o.snap = 1'b1;
        state_d    = rdt_pkg::ST_EVAL;
      end
      rdt_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = rdt_pkg::ST_MUL_TMO;
      end
      rdt_pkg::ST_MUL_TMO: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) begin
          state_d = rdt_pkg::ST_FINISH;
        end
      end
      rdt_pkg::ST_FINISH: begin
        // Wait for the output register to free up
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = rdt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rdt_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != rdt_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ src/rdt_datapath.sv @@
module rdt_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rdt_pkg::in_t                   in_data_i,
  output rdt_pkg::out_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_index_i,
  input  logic [rdt_pkg::CfgW-1:0]       cfg_data_i,
  input  rdt_pkg::cmd_t                  cmd_i,
  output rdt_pkg::sts_t                  sts_o
);

  localparam int unsigned DW  = rdt_pkg::DeadlineW;
  localparam int unsigned SW  = rdt_pkg::StepW;
  localparam int unsigned TW  = rdt_pkg::TimeoutW;
  localparam int unsigned XW  = rdt_pkg::ScaledW;
  localparam int unsigned CW  = rdt_pkg::ChunkW;
  localparam int unsigned US  = rdt_pkg::UsShift;
  localparam int unsigned QS  = rdt_pkg::QuoShift;
  localparam int unsigned AW  = XW + 1;
  localparam int unsigned PW  = XW + CW;
  localparam int unsigned SUW = PW + 1;

  logic [rdt_pkg::CfgW-1:0]   interval_q, granularity_q;
  logic [1:0]                 req_q;
  logic [rdt_pkg::NowW-1:0]   now_q;
  logic [DW-1:0]              t_q, t_d;
  logic [DW-1:0]              deadline_q, deadline_d;
  logic [SW-1:0]              rem_q, rem_d;
  logic [DW-1:0]              quo_q, quo_d;
  logic [rdt_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                       due_q, due_d;
  logic                       sat_q, sat_d;
  logic [XW-1:0]              scaled_q, scaled_d;
  logic [AW-1:0]              acc_q, acc_d;
  logic [rdt_pkg::RecipW-1:0] recip_q, recip_d;
  rdt_pkg::out_t              out_q;

  logic [SW-1:0]   step_us, iv_us;
  logic [DW-1:0]   now_ext, t_sum, t_base, t_snap;
  logic [SW+1:0]   trial;
  logic            round_up;
  logic [DW-1:0]   tmo_us;
  logic [PW-1:0]   prod;
  logic [SUW-1:0]  acc_sum;
  logic [TW-1:0]   tmo_val;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q    <= '0;
      granularity_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == rdt_pkg::CFG_INTERVAL) begin
        interval_q <= cfg_data_i;
      end
      if (cfg_index_i == rdt_pkg::CFG_GRANULARITY) begin
        granularity_q <= cfg_data_i;
      end
    end
  end

  // Arm sum: zero interval counts as one ms
  assign step_us = rdt_pkg::times_1000(granularity_q);
  assign iv_us   = (interval_q == '0) ? rdt_pkg::UsPerMs : rdt_pkg::times_1000(interval_q);
  assign now_ext = {1'b0, now_q};
  assign t_sum   = now_ext + DW'(iv_us);

  // Restoring division step: shift one dividend bit into the remainder
  assign trial   = {1'b0, rem_q, quo_q[DW-1]} - {2'b00, step_us};

  // Snap to the step, round up at a quarter step, then saturate
  assign round_up = (rem_q >= (step_us >> 2));
  assign t_base   = t_q - DW'(rem_q);
  assign t_snap   = (granularity_q == '0) ? t_q :
                    (round_up ? t_base + DW'(step_us) : t_base);

  // Time left plus the round-up term, and one reciprocal multiply step
  assign tmo_us  = deadline_q + rdt_pkg::MsRoundUp - now_ext;
  assign prod    = scaled_q * recip_q[CW-1:0];
  assign acc_sum = SUW'(acc_q) + SUW'(prod);

  // Timeout from the scaled product, saturated, or zero once the deadline is due
  assign tmo_val = due_q ? '0 :
                   (sat_q ? rdt_pkg::TimeoutMax : acc_q[TW+QS-1:QS]);

  always_comb begin
    t_d        = t_q;
    deadline_d = deadline_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    cnt_d      = cnt_q;
    due_d      = due_q;
    sat_d      = sat_q;
    scaled_d   = scaled_q;
    acc_d      = acc_q;
    recip_d    = recip_q;
    if (cmd_i.arm) begin
      t_d   = t_sum;
      quo_d = t_sum;
      rem_d = '0;
      cnt_d = '0;
    end
    if (cmd_i.fire) begin
      deadline_d = now_ext;
    end
    if (cmd_i.div_step) begin
      if (!trial[SW+1]) begin
        rem_d = trial[SW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[SW-2:0], quo_q[DW-1]};
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
    end
    if (cmd_i.snap) begin
      deadline_d = t_snap[DW-1] ? rdt_pkg::DeadlineMax : t_snap;
    end
    if (cmd_i.eval) begin
      due_d    = (deadline_q <= now_ext);
      sat_d    = (tmo_us >= rdt_pkg::TmoSatUs);
      scaled_d = tmo_us[XW+US-1:US];
      acc_d    = '0;
      recip_d  = rdt_pkg::TmoRecip;
      cnt_d    = '0;
    end
    if (cmd_i.mul_step) begin
      acc_d   = acc_sum[SUW-1:CW];
      recip_d = recip_q >> CW;
      cnt_d   = cnt_q + 1'b1;
    end
  end

  // Deadline state and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadline_q <= '0;
      cnt_q      <= '0;
    end else begin
      deadline_q <= deadline_d;
      cnt_q      <= cnt_d;
    end
  end

  // Working payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i.req_type;
      now_q <= in_data_i.now_us;
    end
    t_q      <= t_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    due_q    <= due_d;
    sat_q    <= sat_d;
    scaled_q <= scaled_d;
    acc_q    <= acc_d;
    recip_q  <= recip_d;
    if (cmd_i.out_load) begin
      out_q.due         <= due_q;
      out_q.tmo_ms      <= tmo_val;
      out_q.deadline_us <= signed'(deadline_q);
    end
  end

  assign out_data_o      = out_q;
  assign sts_o.req       = rdt_pkg::req_e'(req_q);
  assign sts_o.gran_zero = (granularity_q == '0);
  assign sts_o.div_last  = &cnt_q;
  assign sts_o.mul_last  = (cnt_q == rdt_pkg::CntW'(rdt_pkg::MulSteps - 1));

endmodule

@@ src/rearmable_deadline_timer.sv @@
// The result is offered after a poll or fire-now transfer once the timeout is formed;
// an arm first forms and saturates the deadline, after a 64-step serial modulo if granularity is set.
// The timeout takes a 4-step reciprocal multiply after the deadline compare.
// One request is in flight at a time; the next transfer is taken the cycle after the
// result loads.
// Reset clears the deadline and both configuration registers to zero.
module rearmable_deadline_timer (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  rdt_pkg::in_t             in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output rdt_pkg::out_t            out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic [rdt_pkg::CfgW-1:0] cfg_data_i
);

  rdt_pkg::cmd_t cmd;
  rdt_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  rdt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rdt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
